@@ hdl/bls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types, register indexes and helpers of the boundary-layer residual
// stencil core.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int QUOT_BITS = 41;
  localparam logic [QUOT_BITS-1:0] TERM_CAP = QUOT_BITS'(1) << (QUOT_BITS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_WALL_F  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_G  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_T  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_G   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_T   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRANDTL = 3'd5;

  typedef struct packed {
    logic signed [31:0] x_pos;
    logic signed [31:0] f_val;
    logic signed [31:0] g_val;
    logic signed [31:0] t_val;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] res_f;
    logic signed [31:0] res_g;
    logic signed [31:0] res_t;
    logic [15:0]        point_index;
    logic               last_result;
    logic               div_fault;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_LASTPREP, ST_ISSUE, ST_WAIT, ST_EMIT, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_HH, OP_DF, OP_MG, OP_DG1, OP_DG2, OP_MP, OP_MT, OP_DT1, OP_DT2, OP_DL
  } op_t;

  typedef enum logic [1:0] {SH_0, SH_F, SH_2F} shift_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num_mag;
    shift_t      shift;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic signed [33:0] a;
    logic signed [33:0] b;
  } mul_req_t;

  // Clamp a signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

@@ hdl/bls_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface bls_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/bls_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_div
// Restoring divider, one quotient bit per cycle, quotient capped at 2^40.
// ----------------------------------------------------------------------------
module bls_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bls_pkg::div_req_t             req,
  output logic                          done,
  output logic [bls_pkg::QUOT_BITS-1:0] quot
);

  localparam int QB = bls_pkg::QUOT_BITS;
  localparam int DW = 64 + 2 * FRAC_BITS;
  localparam int HW = DW - QB;
  localparam int CW = $clog2(QB + 1);

  logic [DW-1:0] dividend;
  logic [HW-1:0] hi;
  logic          over;
  logic [63:0]   rem;
  logic [63:0]   dvs;
  logic [QB-1:0] low;
  logic [QB-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          capped;
  logic [64:0]   trial;
  logic          ge;

  always_comb begin
    case (req.shift)
      bls_pkg::SH_F:  dividend = DW'(req.num_mag) << FRAC_BITS;
      bls_pkg::SH_2F: dividend = DW'(req.num_mag) << (2 * FRAC_BITS);
      default:        dividend = DW'(req.num_mag);
    endcase
    hi    = dividend[DW-1:QB];
    // The quotient reaches 2^41 exactly when the top part is not below the divisor.
    over  = DW'(hi) >= DW'(req.divisor);
    trial = {rem, low[QB-1]};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        capped <= over;
        rem    <= 64'(hi);
        low    <= dividend[QB-1:0];
        dvs    <= req.divisor;
        q      <= '0;
        cnt    <= CW'(QB);
        busy   <= !over;
        done   <= over;
      end else if (busy) begin
        rem <= ge ? 64'(trial - {1'b0, dvs}) : trial[63:0];
        q   <= {q[QB-2:0], ge};
        low <= low << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = (capped || q > bls_pkg::TERM_CAP) ? bls_pkg::TERM_CAP : q;

endmodule

@@ hdl/bls_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_mul
// Shared signed 34 x 34 multiplier with a registered product.
// ----------------------------------------------------------------------------
module bls_mul (
  input  logic                clk,
  input  logic                rst,
  input  bls_pkg::mul_req_t   req,
  output logic                done,
  output logic signed [67:0]  prod
);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req.start;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= 68'(req.a) * 68'(req.b);
    end
  end

endmodule

@@ hdl/boundary_layer_residual_stencil_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_layer_residual_stencil_core
// Residuals of the boundary-layer equations over a streamed mesh.
// ----------------------------------------------------------------------------
// Mesh points enter on the points channel, one beat per point, in mesh order;
// the residuals channel returns one beat per point, also in mesh order. The
// first point of a run yields wall residuals, an interior point is reported
// when its successor arrives, and the point flagged last_point yields the
// far-field residuals, so one input beat gives zero, one or two result beats.
// Targets and the Prandtl number are written through cfg_we/cfg_index/cfg_data;
// the user must do so only while the core is idle, as the core itself does not
// enforce this. Writes to unused indexes are dropped. The core takes one point
// at a time. An interior point runs four multiplies and five divisions on one
// shared restoring divider; a last point adds one more division. The divider
// sets the rate.
// Reset clears the mesh window and point count and loads the register
// defaults. A result waits in the output register while the receiver stalls;
// the core stalls its own sequence only when it must load a further result.
// ----------------------------------------------------------------------------
module boundary_layer_residual_stencil_core #(
  parameter int MAX_POINTS = 65536,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  bls_stream_if.sink                    points,
  bls_stream_if.source                  residuals,
  input  logic                          cfg_we,
  input  logic [bls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int PSW = $clog2(MAX_POINTS + 1);

  // Configuration registers.
  logic signed [31:0] wall_f_target, wall_g_target, wall_t_target;
  logic signed [31:0] far_g_target, far_t_target;
  logic [30:0]        prandtl;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_f_target <= 32'sd0;
      wall_g_target <= 32'sd0;
      wall_t_target <= 32'sd1 <<< FRAC_BITS;
      far_g_target  <= 32'sd1 <<< FRAC_BITS;
      far_t_target  <= 32'sd0;
      prandtl       <= 31'd1 << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        bls_pkg::REG_WALL_F:  wall_f_target <= cfg_data;
        bls_pkg::REG_WALL_G:  wall_g_target <= cfg_data;
        bls_pkg::REG_WALL_T:  wall_t_target <= cfg_data;
        bls_pkg::REG_FAR_G:   far_g_target  <= cfg_data;
        bls_pkg::REG_FAR_T:   far_t_target  <= cfg_data;
        bls_pkg::REG_PRANDTL: prandtl       <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  bls_pkg::state_t    state, state_next;
  bls_pkg::op_t       op;
  bls_pkg::point_t    item;
  bls_pkg::result_t   pend;
  bls_pkg::result_t   out_data;
  logic               out_valid;
  logic               out_load;
  logic signed [31:0] window_x [2];
  logic signed [31:0] window_f [2];
  logic signed [31:0] window_g [2];
  logic signed [31:0] window_t [2];
  logic [PSW-1:0]     ps;
  logic [31:0]        hmag;
  logic               hneg;
  logic [63:0]        hh;
  logic signed [67:0] prod_q;
  logic signed [31:0] prt;
  logic signed [41:0] q_a;
  logic               div_neg;

  // Shared units.
  bls_pkg::div_req_t  div_req;
  bls_pkg::mul_req_t  mul_req;
  logic               div_done, mul_done;
  logic [bls_pkg::QUOT_BITS-1:0] quot;
  logic signed [67:0] mul_prod;

  bls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (quot)
  );

  bls_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  // Combinational helpers.
  logic signed [32:0] h_int, h_last;
  logic signed [35:0] lap_g, lap_t;
  logic signed [67:0] num;
  logic               num_neg_div;
  logic               op_is_mul;
  logic               unit_done;
  logic signed [41:0] qs;
  logic [63:0]        pmag, psh;
  logic signed [31:0] prt_val;
  logic [15:0]        idx_int, idx_last;
  logic               ps_ge2;

  always_comb begin
    h_int  = 33'(window_x[1]) - 33'(window_x[0]);
    h_last = 33'(item.x_pos) - 33'(window_x[1]);
    // Second differences, already doubled.
    lap_g  = (36'(window_g[0]) - 36'(window_g[1]) - 36'(window_g[1]) + 36'(item.g_val)) <<< 1;
    lap_t  = (36'(window_t[0]) - 36'(window_t[1]) - 36'(window_t[1]) + 36'(item.t_val)) <<< 1;
    op_is_mul = (op == bls_pkg::OP_HH) || (op == bls_pkg::OP_MG) ||
                (op == bls_pkg::OP_MP) || (op == bls_pkg::OP_MT);
    unit_done = op_is_mul ? mul_done : div_done;
    qs      = div_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    ps_ge2  = ps >= PSW'(2);
    idx_int = 16'(ps - 1'b1);
    idx_last = 16'((ps >= PSW'(MAX_POINTS)) ? PSW'(MAX_POINTS - 1) : ps);

    // Pr*f truncated toward zero and clamped.
    pmag = mul_prod[67] ? 64'(-mul_prod) : 64'(mul_prod);
    psh  = pmag >> FRAC_BITS;
    if (!mul_prod[67]) begin
      prt_val = (psh > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(psh);
    end else begin
      prt_val = (psh > 64'h80000000) ? 32'sh80000000 : 32'(-psh);
    end

    // Operand selection for the shared units.
    num                 = '0;
    num_neg_div         = 1'b0;
    div_req.start       = 1'b0;
    div_req.shift       = bls_pkg::SH_0;
    div_req.divisor     = 64'(hmag);
    mul_req.start       = 1'b0;
    mul_req.a           = '0;
    mul_req.b           = '0;
    case (op)
      bls_pkg::OP_HH: begin
        mul_req.a = 34'($signed({1'b0, hmag}));
        mul_req.b = 34'($signed({1'b0, hmag}));
      end
      bls_pkg::OP_MG: begin
        mul_req.a = 34'(window_f[1]);
        mul_req.b = 34'(33'(window_g[1]) - 33'(window_g[0]));
      end
      bls_pkg::OP_MP: begin
        mul_req.a = 34'($signed({1'b0, prandtl}));
        mul_req.b = 34'(window_f[1]);
      end
      bls_pkg::OP_MT: begin
        mul_req.a = 34'(prt);
        mul_req.b = 34'(33'(item.t_val) - 33'(window_t[1]));
      end
      bls_pkg::OP_DF: begin
        num           = 68'(33'(window_f[1]) - 33'(window_f[0]));
        div_req.shift = bls_pkg::SH_F;
        num_neg_div   = hneg;
      end
      bls_pkg::OP_DG1, bls_pkg::OP_DT1: begin
        num         = prod_q;
        num_neg_div = hneg;
      end
      bls_pkg::OP_DG2: begin
        num             = 68'(lap_g);
        div_req.shift   = bls_pkg::SH_2F;
        div_req.divisor = hh;
      end
      bls_pkg::OP_DT2: begin
        num             = 68'(lap_t);
        div_req.shift   = bls_pkg::SH_2F;
        div_req.divisor = hh;
      end
      bls_pkg::OP_DL: begin
        num           = 68'(33'(item.f_val) - 33'(window_f[1]));
        div_req.shift = bls_pkg::SH_F;
        num_neg_div   = hneg;
      end
      default: ;
    endcase
    div_req.num_mag = num[67] ? 64'(-num) : 64'(num);
    div_req.start   = (state == bls_pkg::ST_ISSUE) && !op_is_mul;
    mul_req.start   = (state == bls_pkg::ST_ISSUE) && op_is_mul;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bls_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next    = state;
    out_load      = 1'b0;
    points.ready  = 1'b0;
    case (state)
      bls_pkg::ST_IDLE: begin
        // No point is taken while reset is held.
        points.ready = !rst;
        if (points.valid) begin
          state_next = bls_pkg::ST_DECIDE;
        end
      end
      bls_pkg::ST_DECIDE: begin
        if (ps == '0) begin
          state_next = bls_pkg::ST_EMIT;
        end else if (ps_ge2) begin
          state_next = (h_int == '0) ? bls_pkg::ST_EMIT : bls_pkg::ST_ISSUE;
        end else begin
          state_next = item.last_point ? bls_pkg::ST_LASTPREP : bls_pkg::ST_DONE;
        end
      end
      bls_pkg::ST_LASTPREP: begin
        state_next = (h_last == '0) ? bls_pkg::ST_EMIT : bls_pkg::ST_ISSUE;
      end
      bls_pkg::ST_ISSUE: begin
        state_next = bls_pkg::ST_WAIT;
      end
      bls_pkg::ST_WAIT: begin
        if (unit_done) begin
          if (op == bls_pkg::OP_DT2 || op == bls_pkg::OP_DL) begin
            state_next = bls_pkg::ST_EMIT;
          end else begin
            state_next = bls_pkg::ST_ISSUE;
          end
        end
      end
      bls_pkg::ST_EMIT: begin
        if (!out_valid || residuals.ready) begin
          out_load   = 1'b1;
          // An interior result of a last point is followed by its far-field result.
          state_next = (!pend.last_result && item.last_point) ?
                       bls_pkg::ST_LASTPREP : bls_pkg::ST_DONE;
        end
      end
      bls_pkg::ST_DONE: begin
        state_next = bls_pkg::ST_IDLE;
      end
      default: state_next = bls_pkg::ST_IDLE;
    endcase
  end

  // Window and point count.
  always_ff @(posedge clk) begin
    if (rst) begin
      ps <= '0;
      for (int i = 0; i < 2; i++) begin
        window_x[i] <= '0;
        window_f[i] <= '0;
        window_g[i] <= '0;
        window_t[i] <= '0;
      end
    end else if (state == bls_pkg::ST_DONE) begin
      if (ps == '0) begin
        if (!item.last_point) begin
          window_x[1] <= item.x_pos;
          window_f[1] <= item.f_val;
          window_g[1] <= item.g_val;
          window_t[1] <= item.t_val;
          ps          <= PSW'(1);
        end
      end else if (item.last_point) begin
        ps <= '0;
      end else begin
        window_x[0] <= window_x[1];
        window_f[0] <= window_f[1];
        window_g[0] <= window_g[1];
        window_t[0] <= window_t[1];
        window_x[1] <= item.x_pos;
        window_f[1] <= item.f_val;
        window_g[1] <= item.g_val;
        window_t[1] <= item.t_val;
        if (ps < PSW'(MAX_POINTS)) begin
          ps <= ps + 1'b1;
        end
      end
    end
  end

  // Arithmetic datapath.
  always_ff @(posedge clk) begin
    case (state)
      bls_pkg::ST_IDLE: begin
        if (points.valid) begin
          item <= points.data;
        end
      end
      bls_pkg::ST_DECIDE: begin
        if (ps == '0) begin
          pend.res_f       <= bls_pkg::sat32(48'(item.f_val) - 48'(wall_f_target));
          pend.res_g       <= bls_pkg::sat32(48'(item.g_val) - 48'(wall_g_target));
          pend.res_t       <= bls_pkg::sat32(48'(item.t_val) - 48'(wall_t_target));
          pend.point_index <= '0;
          pend.last_result <= item.last_point;
          pend.div_fault   <= 1'b0;
        end else begin
          hmag <= h_int[32] ? 32'(-h_int) : 32'(h_int);
          hneg <= h_int[32];
          op   <= bls_pkg::OP_HH;
          // Zero spacing on an interior point gives an all-zero faulted result.
          pend.res_f       <= '0;
          pend.res_g       <= '0;
          pend.res_t       <= '0;
          pend.point_index <= idx_int;
          pend.last_result <= 1'b0;
          pend.div_fault   <= 1'b1;
        end
      end
      bls_pkg::ST_LASTPREP: begin
        hmag             <= h_last[32] ? 32'(-h_last) : 32'(h_last);
        hneg             <= h_last[32];
        op               <= bls_pkg::OP_DL;
        pend.res_f       <= '0;
        pend.res_g       <= bls_pkg::sat32(48'(item.g_val) - 48'(far_g_target));
        pend.res_t       <= bls_pkg::sat32(48'(item.t_val) - 48'(far_t_target));
        pend.point_index <= idx_last;
        pend.last_result <= 1'b1;
        pend.div_fault   <= (h_last == '0);
      end
      bls_pkg::ST_ISSUE: begin
        div_neg <= num[67] ^ num_neg_div;
      end
      bls_pkg::ST_WAIT: begin
        if (unit_done) begin
          case (op)
            bls_pkg::OP_HH: begin
              hh <= mul_prod[63:0];
              op <= bls_pkg::OP_DF;
            end
            bls_pkg::OP_DF: begin
              pend.res_f <= bls_pkg::sat32(48'(qs) - 48'(window_g[1]));
              op         <= bls_pkg::OP_MG;
            end
            bls_pkg::OP_MG: begin
              prod_q <= mul_prod;
              op     <= bls_pkg::OP_DG1;
            end
            bls_pkg::OP_DG1: begin
              q_a <= qs;
              op  <= bls_pkg::OP_DG2;
            end
            bls_pkg::OP_DG2: begin
              pend.res_g <= bls_pkg::sat32(48'(q_a) + 48'(qs));
              op         <= bls_pkg::OP_MP;
            end
            bls_pkg::OP_MP: begin
              prt <= prt_val;
              op  <= bls_pkg::OP_MT;
            end
            bls_pkg::OP_MT: begin
              prod_q <= mul_prod;
              op     <= bls_pkg::OP_DT1;
            end
            bls_pkg::OP_DT1: begin
              q_a <= qs;
              op  <= bls_pkg::OP_DT2;
            end
            bls_pkg::OP_DT2: begin
              pend.res_t     <= bls_pkg::sat32(48'(q_a) + 48'(qs));
              pend.div_fault <= 1'b0;
            end
            bls_pkg::OP_DL: begin
              pend.res_f <= bls_pkg::sat32(48'(qs) - 48'(item.g_val));
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (residuals.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= pend;
    end
  end

  assign residuals.valid = out_valid;
  assign residuals.data  = out_data;

  // A taken point always starts its evaluation on the next cycle.
  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    (points.valid && points.ready) |=> (state == bls_pkg::ST_DECIDE))
    else $error("accepted point did not enter evaluation");

  // The divider only reports back while the sequencer waits on a division.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == bls_pkg::ST_WAIT && !op_is_mul))
    else $error("divider result arrived outside a division step");

  // A finished last point ends the run.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (state == bls_pkg::ST_DONE && item.last_point) |=> (ps == '0))
    else $error("point count not cleared after last point");

endmodule
